>>> sv/cdad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cdad_pkg
// Shared types, constants and calendar helpers for the date add-days unit.
// ============================================================================
package cdad_pkg;

    // Field widths of the transaction payload
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 17;

    // Working widths: year may leave 0..16383 by about 180 during the walk;
    // the day accumulator holds the widest clamped offset plus a day of month
    localparam int YACC_W = 16;
    localparam int DACC_W = 25;

    // Month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Valid result year range and the saturated dates
    localparam logic signed [YACC_W-1:0] YEAR_MIN = 16'sd1;
    localparam logic signed [YACC_W-1:0] YEAR_MAX = 16'sd9999;
    localparam logic [DAY_W-1:0]         DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]         DAY_LAST_DEC = 5'd31;

    // Year split into year mod 100 and century mod 4
    localparam logic [6:0]  CENT_LAST   = 7'd99;
    localparam logic [12:0] DIV100_MUL  = 13'd5243;
    localparam int          DIV100_SHR  = 19;
    localparam logic [6:0]  HUNDRED     = 7'd100;

    typedef logic signed [YACC_W-1:0] t_year_acc;
    typedef logic signed [DACC_W-1:0] t_day_acc;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic divq;
        logic divr;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic walk_done;
    } t_dp_stat;

    // Leap year from year mod 100 and (year div 100) mod 4
    function automatic logic f_is_leap(input logic [6:0] m100, input logic [1:0] c4);
        logic leap;
        if (m100 != 7'd0) begin
            leap = (m100[1:0] == 2'd0);
        end else begin
            leap = (c4 == 2'd0);
        end
        return leap;
    endfunction

    // Month length table
    function automatic logic [DAY_W-1:0] f_days_in_month(input logic [MONTH_W-1:0] month,
                                                         input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> sv/calendar_date_add_days_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// calendar_date_add_days_unit
// Gregorian date plus a signed day offset, walked one month per cycle.
// ============================================================================
// Usage:
//   Input channel: i_in_valid / o_in_stall carry year, month, day and a signed
//   offset. A transaction is taken when valid is high and stall is low.
//   Output channel: o_out_valid / i_out_stall carry the resulting date and a
//   range error flag; a result is taken when valid is high and stall is low.
//   Sequence: the accepting edge loads the date, the DIVQ and DIVR states split
//   the year into year mod 100 and century mod 4, then the WALK state crosses
//   one month per step and a final finish step loads the output register. The
//   largest offset crosses about 2155 months.
//   Flow: one transaction at a time; the next one is taken in the cycle
//   after the previous result reaches the output register, so the length of
//   the month walk sets the rate.
//   A pending result waits in the output register while the next transaction
//   is accepted and walked; if the receiver still stalls when that walk ends,
//   the walk holds its result until the register drains.
//   Reset (synchronous, active low) empties the controller and the output
//   register; no memory needs clearing.
// ============================================================================
module calendar_date_add_days_unit #(
    parameter int MAX_OFFSET_DAYS = 65535
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [cdad_pkg::YEAR_W-1:0]            i_year_in,
    input  wire logic [cdad_pkg::MONTH_W-1:0]           i_month_in,
    input  wire logic [cdad_pkg::DAY_W-1:0]             i_day_in,
    input  wire logic signed [cdad_pkg::OFFSET_W-1:0]   i_day_offset,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [cdad_pkg::YEAR_W-1:0]                 o_year_out,
    output logic [cdad_pkg::MONTH_W-1:0]                o_month_out,
    output logic [cdad_pkg::DAY_W-1:0]                  o_day_out,
    output logic                                        o_range_error
);
    import cdad_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    cdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Date registers and month walk
    cdad_datapath #(
        .MAX_OFFSET_DAYS (MAX_OFFSET_DAYS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_day_offset  (i_day_offset),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_range_error (o_range_error)
    );

endmodule
`default_nettype wire

>>> sv/cdad_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cdad_ctrl
// Sequencer: accepts a transaction, runs the year split and the month walk,
// and hands the result to the output register when it is free.
// ============================================================================
module cdad_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output cdad_pkg::t_dp_cmd       o_cmd,
    input  wire cdad_pkg::t_dp_stat i_stat
);
    import cdad_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIVQ = 2'd1;
    localparam logic [1:0] S_DIVR = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // Output register can take a result when empty or being drained
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode commands and next state
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIVQ;
                end
            end
            S_DIVQ: begin
                o_cmd.divq = 1'b1;
                n_state    = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.divr = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (!i_stat.walk_done) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> sv/cdad_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cdad_datapath
// Working date registers, year mod 100 tracking, one month step per command,
// and the saturating output register.
// ============================================================================
module cdad_datapath #(
    parameter int MAX_OFFSET_DAYS = 65535
) (
    input  wire logic                           i_clk,
    input  wire cdad_pkg::t_dp_cmd              i_cmd,
    output cdad_pkg::t_dp_stat                  o_stat,
    input  wire logic [cdad_pkg::YEAR_W-1:0]    i_year_in,
    input  wire logic [cdad_pkg::MONTH_W-1:0]   i_month_in,
    input  wire logic [cdad_pkg::DAY_W-1:0]     i_day_in,
    input  wire logic signed [cdad_pkg::OFFSET_W-1:0] i_day_offset,
    output logic [cdad_pkg::YEAR_W-1:0]         o_year_out,
    output logic [cdad_pkg::MONTH_W-1:0]        o_month_out,
    output logic [cdad_pkg::DAY_W-1:0]          o_day_out,
    output logic                                o_range_error
);
    import cdad_pkg::*;

    localparam int CLAMP_W = 25;
    localparam logic signed [CLAMP_W-1:0] OFF_HI = CLAMP_W'(MAX_OFFSET_DAYS);
    localparam logic signed [CLAMP_W-1:0] OFF_LO = -OFF_HI;

    t_year_acc          r_year;
    logic [MONTH_W-1:0] r_month;
    t_day_acc           r_day;
    logic [6:0]         r_m100;
    logic [1:0]         r_c4;
    logic [7:0]         r_quot;

    logic signed [CLAMP_W-1:0] off_ext, off_clamp, day_sum;
    logic [MONTH_W-1:0]        month_clamp;
    logic [26:0]               quot_prod;
    logic [YEAR_W-1:0]         rem_full;

    logic [DAY_W-1:0]   dim_cur, dim_prev;
    logic               fwd, bwd;
    logic [MONTH_W-1:0] next_month, prev_month;
    t_year_acc          next_year, prev_year;
    logic [6:0]         next_m100, prev_m100;
    logic [1:0]         next_c4, prev_c4;

    // Clamp the offset and the month, then fold the offset into the day
    always_comb begin
        off_ext = CLAMP_W'(i_day_offset);
        if (off_ext > OFF_HI) begin
            off_clamp = OFF_HI;
        end else if (off_ext < OFF_LO) begin
            off_clamp = OFF_LO;
        end else begin
            off_clamp = off_ext;
        end
        day_sum = off_clamp + $signed({{(CLAMP_W-DAY_W){1'b0}}, i_day_in});
        if (i_month_in < MONTH_JAN) begin
            month_clamp = MONTH_JAN;
        end else if (i_month_in > MONTH_DEC) begin
            month_clamp = MONTH_DEC;
        end else begin
            month_clamp = i_month_in;
        end
    end

    // Year split: quotient by reciprocal, remainder by constant multiply
    assign quot_prod = r_year[YEAR_W-1:0] * DIV100_MUL;
    assign rem_full  = r_year[YEAR_W-1:0] - YEAR_W'(r_quot * HUNDRED);

    // Next month on carry
    always_comb begin
        if (r_month == MONTH_DEC) begin
            next_month = MONTH_JAN;
            next_year  = r_year + t_year_acc'(1);
            if (r_m100 == CENT_LAST) begin
                next_m100 = 7'd0;
                next_c4   = r_c4 + 2'd1;
            end else begin
                next_m100 = r_m100 + 7'd1;
                next_c4   = r_c4;
            end
        end else begin
            next_month = r_month + 4'd1;
            next_year  = r_year;
            next_m100  = r_m100;
            next_c4    = r_c4;
        end
    end

    // Previous month on borrow
    always_comb begin
        if (r_month == MONTH_JAN) begin
            prev_month = MONTH_DEC;
            prev_year  = r_year - t_year_acc'(1);
            if (r_m100 == 7'd0) begin
                prev_m100 = CENT_LAST;
                prev_c4   = r_c4 - 2'd1;
            end else begin
                prev_m100 = r_m100 - 7'd1;
                prev_c4   = r_c4;
            end
        end else begin
            prev_month = r_month - 4'd1;
            prev_year  = r_year;
            prev_m100  = r_m100;
            prev_c4    = r_c4;
        end
    end

    // Compare the day against the current month
    assign dim_cur  = f_days_in_month(r_month, f_is_leap(r_m100, r_c4));
    assign dim_prev = f_days_in_month(prev_month, f_is_leap(prev_m100, prev_c4));
    assign fwd = r_day > $signed({{(DACC_W-DAY_W){1'b0}}, dim_cur});
    assign bwd = r_day[DACC_W-1] || (r_day == '0);
    assign o_stat.walk_done = !fwd && !bwd;

    // Load, split the year, then step one month per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= t_year_acc'({2'b00, i_year_in});
            r_month <= month_clamp;
            r_day   <= day_sum[DACC_W-1:0];
        end
        if (i_cmd.divq) begin
            r_quot <= quot_prod[DIV100_SHR +: 8];
        end
        if (i_cmd.divr) begin
            r_m100 <= rem_full[6:0];
            r_c4   <= r_quot[1:0];
        end
        if (i_cmd.step) begin
            if (fwd) begin
                r_day   <= r_day - $signed({{(DACC_W-DAY_W){1'b0}}, dim_cur});
                r_month <= next_month;
                r_year  <= next_year;
                r_m100  <= next_m100;
                r_c4    <= next_c4;
            end else begin
                r_day   <= r_day + $signed({{(DACC_W-DAY_W){1'b0}}, dim_prev});
                r_month <= prev_month;
                r_year  <= prev_year;
                r_m100  <= prev_m100;
                r_c4    <= prev_c4;
            end
        end
    end

    // Saturate the year and load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_year < YEAR_MIN) begin
                o_year_out    <= YEAR_MIN[YEAR_W-1:0];
                o_month_out   <= MONTH_JAN;
                o_day_out     <= DAY_FIRST;
                o_range_error <= 1'b1;
            end else if (r_year > YEAR_MAX) begin
                o_year_out    <= YEAR_MAX[YEAR_W-1:0];
                o_month_out   <= MONTH_DEC;
                o_day_out     <= DAY_LAST_DEC;
                o_range_error <= 1'b1;
            end else begin
                o_year_out    <= r_year[YEAR_W-1:0];
                o_month_out   <= r_month;
                o_day_out     <= r_day[DAY_W-1:0];
                o_range_error <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_calendar_date_add_days_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_calendar_date_add_days_unit
// Self-checking bench for the Gregorian date plus signed day offset unit.
// ============================================================================
// A directed table covers the calendar edges first: leap rules, month and
// day normalization, offset clamping and year saturation at both ends. Random
// transactions follow, mostly well-formed dates with small offsets and a few
// that span the whole offset range. Every result is checked field by field,
// against a typed row's date or a month-walking predictor, in order of
// acceptance. Both channels idle at random but for one full-rate stretch.
// ============================================================================
module tb_calendar_date_add_days_unit;

    localparam int MAX_SHIFT     = 65535;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 23;
    localparam int RANDOM_ITEMS  = 247;
    localparam int STEADY_FIRST  = 100;
    localparam int STEADY_LAST   = 159;
    localparam int DRAIN_CYCLES  = 40;
    localparam int QUIET_LIMIT   = 20000;
    localparam int N_DIRECTED    = 23;
    localparam int MONTHS_IN_YR  = 12;
    localparam int YEAR_LOW      = 1;
    localparam int YEAR_HIGH     = 9999;
    localparam int DAY_LAST_DEC  = 31;

    typedef struct packed {
        logic [cdad_pkg::YEAR_W-1:0]   year;
        logic [cdad_pkg::MONTH_W-1:0]  month;
        logic [cdad_pkg::DAY_W-1:0]    day;
        logic [cdad_pkg::OFFSET_W-1:0] offset;
    } t_date_req;

    typedef struct packed {
        logic [cdad_pkg::YEAR_W-1:0]  year;
        logic [cdad_pkg::MONTH_W-1:0] month;
        logic [cdad_pkg::DAY_W-1:0]   day;
        logic                         range_error;
    } t_date_res;

    // One stimulus row; typed rows carry their expected date
    typedef struct packed {
        logic [cdad_pkg::YEAR_W-1:0]   year;
        logic [cdad_pkg::MONTH_W-1:0]  month;
        logic [cdad_pkg::DAY_W-1:0]    day;
        logic [cdad_pkg::OFFSET_W-1:0] offset;
        logic                          typed;
        logic [cdad_pkg::YEAR_W-1:0]   year_exp;
        logic [cdad_pkg::MONTH_W-1:0]  month_exp;
        logic [cdad_pkg::DAY_W-1:0]    day_exp;
        logic                          err_exp;
    } t_date_row;

    localparam t_date_row DIRECTED_ROWS [N_DIRECTED] = '{
        // zero offset right after reset
        '{14'd2024, 4'd1,  5'd1,  17'sd0,      1'b1, 14'd2024, 4'd1,  5'd1,  1'b0},
        // one day below the first date saturates low
        '{14'd1,    4'd1,  5'd1,  -17'sd1,     1'b1, 14'd1,    4'd1,  5'd1,  1'b1},
        // one day past the last date saturates high
        '{14'd9999, 4'd12, 5'd31, 17'sd1,      1'b1, 14'd9999, 4'd12, 5'd31, 1'b1},
        '{14'd9999, 4'd12, 5'd31, 17'sd65535,  1'b1, 14'd9999, 4'd12, 5'd31, 1'b1},
        '{14'd1,    4'd1,  5'd1,  -17'sd65535, 1'b1, 14'd1,    4'd1,  5'd1,  1'b1},
        // most negative offset clamped to the bound, then the largest positive one
        '{14'd9999, 4'd12, 5'd31, 17'h10000,   1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd1,    4'd1,  5'd1,  17'sd65535,  1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        // leap rules: by four, not a century, a fourth century
        '{14'd2024, 4'd2,  5'd28, 17'sd1,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd1900, 4'd2,  5'd28, 17'sd1,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd2000, 4'd2,  5'd28, 17'sd1,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        // month out of range clamps to January or December
        '{14'd2023, 4'd0,  5'd15, 17'sd0,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd2023, 4'd13, 5'd15, 17'sd0,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd2023, 4'd15, 5'd31, 17'sd1,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        // day zero and day beyond the month length normalize
        '{14'd2023, 4'd3,  5'd0,  17'sd0,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd2023, 4'd4,  5'd31, 17'sd0,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        // year outside the legal range on input
        '{14'd0,    4'd6,  5'd15, 17'sd400,    1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd0,    4'd6,  5'd15, 17'sd0,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd16383, 4'd1, 5'd1,  -17'sd65535, 1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd10000, 4'd1, 5'd1,  -17'sd366,   1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        // borrow into a leap February, carry into the last year, borrow below year 1, a long walk back
        '{14'd2024, 4'd3,  5'd1,  -17'sd1,     1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd9998, 4'd12, 5'd31, 17'sd1,      1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd1,    4'd1,  5'd31, -17'sd31,    1'b0, 14'd0,    4'd0,  5'd0,  1'b0},
        '{14'd2023, 4'd2,  5'd31, -17'sd30000, 1'b0, 14'd0,    4'd0,  5'd0,  1'b0}
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [cdad_pkg::YEAR_W-1:0]          i_year_in = '0;
    logic [cdad_pkg::MONTH_W-1:0]         i_month_in = '0;
    logic [cdad_pkg::DAY_W-1:0]           i_day_in = '0;
    logic signed [cdad_pkg::OFFSET_W-1:0] i_day_offset = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic [cdad_pkg::YEAR_W-1:0]          o_year_out;
    logic [cdad_pkg::MONTH_W-1:0]         o_month_out;
    logic [cdad_pkg::DAY_W-1:0]           o_day_out;
    logic                                 o_range_error;

    t_date_res shifted_dates[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        steady_flow = 1'b0;

    calendar_date_add_days_unit #(
        .MAX_OFFSET_DAYS(MAX_SHIFT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_day_offset  (i_day_offset),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_range_error (o_range_error)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Month length under the Gregorian leap rule
    function automatic int days_in_month_of(input int yr, input int mon);
        bit leap;
        int len;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mon)
            2:            len = leap ? 29 : 28;
            4, 6, 9, 11:  len = 30;
            default:      len = 31;
        endcase
        return len;
    endfunction

    // Walk the calendar month by month from the offset day
    function automatic t_date_res predict_shifted_date(input t_date_req req);
        int        yr;
        int        mon;
        int        dy;
        int        shift;
        t_date_res res;
        yr    = int'(req.year);
        mon   = int'(req.month);
        dy    = int'(req.day);
        shift = int'($signed(req.offset));
        if (shift > MAX_SHIFT) shift = MAX_SHIFT;
        if (shift < -MAX_SHIFT) shift = -MAX_SHIFT;
        if (mon < 1) mon = 1;
        if (mon > MONTHS_IN_YR) mon = MONTHS_IN_YR;
        dy = dy + shift;
        // carry whole months forward
        while (dy > days_in_month_of(yr, mon)) begin
            dy  = dy - days_in_month_of(yr, mon);
            mon = mon + 1;
            if (mon > MONTHS_IN_YR) begin
                mon = 1;
                yr  = yr + 1;
            end
        end
        // borrow whole months backward
        while (dy <= 0) begin
            mon = mon - 1;
            if (mon < 1) begin
                mon = MONTHS_IN_YR;
                yr  = yr - 1;
            end
            dy = dy + days_in_month_of(yr, mon);
        end
        res.range_error = 1'b0;
        if (yr < YEAR_LOW) begin
            yr = YEAR_LOW;
            mon = 1;
            dy = 1;
            res.range_error = 1'b1;
        end else if (yr > YEAR_HIGH) begin
            yr = YEAR_HIGH;
            mon = MONTHS_IN_YR;
            dy = DAY_LAST_DEC;
            res.range_error = 1'b1;
        end
        res.year  = 14'(yr);
        res.month = 4'(mon);
        res.day   = 5'(dy);
        return res;
    endfunction

    // Draw mostly well-formed dates; the rest is raw field noise
    function automatic t_date_req pick_random_date();
        t_date_req req;
        int        yr;
        int        mon;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 78) begin
            if ($urandom_range(9) == 0) begin
                yr = ($urandom_range(1) == 0) ? $urandom_range(3, 1) : $urandom_range(9999, 9997);
            end else begin
                yr = $urandom_range(9999, 1);
            end
            mon       = $urandom_range(12, 1);
            req.year  = 14'(yr);
            req.month = 4'(mon);
            req.day   = 5'($urandom_range(days_in_month_of(yr, mon), 1));
        end else begin
            req.year  = 14'($urandom_range(16383));
            req.month = 4'($urandom_range(15));
            req.day   = 5'($urandom_range(31));
        end
        // keep most offsets short so the month walk stays quick
        pick = $urandom_range(99);
        if (pick < 55) begin
            req.offset = 17'(int'($urandom_range(800)) - 400);
        end else if (pick < 85) begin
            req.offset = 17'(int'($urandom_range(40000)) - 20000);
        end else begin
            req.offset = 17'($urandom_range(131071));
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Drive one transaction, idling first at random, and hold until taken
    task automatic send_date(input t_date_req req, input t_date_res want);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_year_in    <= req.year;
        i_month_in   <= req.month;
        i_day_in     <= req.day;
        i_day_offset <= $signed(req.offset);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shifted_dates.push_back(want);
    endtask

    // Stall the result channel at random outside the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || steady_flow) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Check each accepted result against the oldest pending date
    always @(posedge i_clk) begin : result_check
        t_date_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shifted_dates.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d/%0d with nothing pending",
                                          o_year_out, o_month_out, o_day_out));
            end else begin
                want = shifted_dates.pop_front();
                if (o_year_out !== want.year)
                    report_mismatch($sformatf("year got %0d want %0d", o_year_out, want.year));
                if (o_month_out !== want.month)
                    report_mismatch($sformatf("month got %0d want %0d",
                                              o_month_out, want.month));
                if (o_day_out !== want.day)
                    report_mismatch($sformatf("day got %0d want %0d", o_day_out, want.day));
                if (o_range_error !== want.range_error)
                    report_mismatch($sformatf("range_error got %0b want %0b",
                                              o_range_error, want.range_error));
            end
        end
    end

    // Count cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_date_req req;
        t_date_res want;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            req.year   = DIRECTED_ROWS[r].year;
            req.month  = DIRECTED_ROWS[r].month;
            req.day    = DIRECTED_ROWS[r].day;
            req.offset = DIRECTED_ROWS[r].offset;
            if (DIRECTED_ROWS[r].typed) begin
                want.year        = DIRECTED_ROWS[r].year_exp;
                want.month       = DIRECTED_ROWS[r].month_exp;
                want.day         = DIRECTED_ROWS[r].day_exp;
                want.range_error = DIRECTED_ROWS[r].err_exp;
            end else begin
                want = predict_shifted_date(req);
            end
            send_date(req, want);
        end

        // random dates, with one stretch at full rate on both sides
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= STEADY_FIRST) && (n <= STEADY_LAST);
            req = pick_random_date();
            send_date(req, predict_shifted_date(req));
        end
        steady_flow = 1'b0;
        i_in_valid <= 1'b0;

        // drain pending results, then watch for strays
        while (shifted_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
